[sv/fls_pkg.sv]
package fls_pkg;

    localparam int MAX_FIB_INDEX = 47;
    localparam int FRAC_BITS     = 16;
    localparam int RATIO_BITS    = 30;

    // F(0) = F(1) = 1, used only at elaboration to size the sequence registers.
    function automatic longint unsigned fib_at(input int idx);
        longint unsigned f0;
        longint unsigned f1;
        longint unsigned f2;
        f0 = 64'd1;
        f1 = 64'd1;
        for (int k = 2; k <= idx; k++) begin
            f2 = f0 + f1;
            f0 = f1;
            f1 = f2;
        end
        return f1;
    endfunction

    localparam int FIB_W   = $clog2(fib_at(MAX_FIB_INDEX) + 64'd1);
    localparam int IDX_W   = $clog2(MAX_FIB_INDEX + 1);
    localparam int CNT_W   = $clog2(RATIO_BITS + 1);
    localparam int RATIO_W = RATIO_BITS + 1;
    localparam int P_W     = 34;
    localparam int MUL_W   = 34;
    localparam int PROD_W  = 2 * MUL_W;
    localparam int WIDE_W  = PROD_W + 2;

    typedef logic signed [MUL_W-1:0]  t_mul;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [WIDE_W-1:0] t_wide;

    // Division by three: offset to a non-negative value that is a multiple of
    // three away, then multiply by the rounded-up reciprocal.
    localparam longint THIRD_OFS   = 64'sd2147483649;
    localparam longint THIRD_K     = 64'sd715827883;
    localparam longint RECIP3      = 64'sd5726623062;
    localparam int     RECIP_SHIFT = 34;

    localparam t_prod ROUND_F = t_prod'(1) <<< (FRAC_BITS - 1);
    localparam t_prod ROUND_R = t_prod'(1) <<< (RATIO_BITS - 1);
    localparam t_wide ONE_FX  = t_wide'(1) <<< FRAC_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_COUNT, S_DIV1, S_WAIT1, S_DIV2, S_WAIT2,
        S_PMUL, S_PROBE, S_SQMUL, S_SQ, S_CUMUL, S_CU, S_THMUL, S_FVAL,
        S_STEP, S_DONE
    } t_state;

    typedef struct packed {
        logic              start;
        logic [FIB_W-1:0]  num;
        logic [FIB_W-1:0]  den;
    } t_div_req;

    typedef struct packed {
        logic               ovf;
        logic signed [31:0] val;
    } t_sat;

    function automatic t_sat sat32(input t_wide v);
        t_sat s;
        if (v > t_wide'(64'sd2147483647)) begin
            s.ovf = 1'b1;
            s.val = 32'sh7FFFFFFF;
        end else if (v < t_wide'(-64'sd2147483648)) begin
            s.ovf = 1'b1;
            s.val = 32'sh80000000;
        end else begin
            s.ovf = 1'b0;
            s.val = v[31:0];
        end
        return s;
    endfunction

endpackage

[sv/fls_div.sv]
module fls_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  fls_pkg::t_div_req              i_req,
    output logic [fls_pkg::RATIO_W-1:0]    o_ratio,
    output logic                           o_done
);

    logic                          r_busy;
    logic                          r_done;
    logic [fls_pkg::CNT_W-1:0]     r_cnt;
    logic [fls_pkg::FIB_W-1:0]     r_rem;
    logic [fls_pkg::FIB_W-1:0]     r_den;
    logic [fls_pkg::RATIO_W-1:0]   r_q;
    logic [fls_pkg::FIB_W:0]       w_rem2;
    logic                          w_ge;

    // The remainder stays below the divisor, so doubling it needs one bit more.
    assign w_rem2 = {r_rem, 1'b0};
    assign w_ge   = (w_rem2 >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start && !r_busy) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == fls_pkg::CNT_W'(fls_pkg::RATIO_BITS)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start && !r_busy) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_q   <= '0;
        end else if (r_busy) begin
            if (r_cnt == fls_pkg::CNT_W'(fls_pkg::RATIO_BITS)) begin
                // Round to nearest, ties up.
                if (w_ge) begin
                    r_q <= r_q + 1'b1;
                end
            end else begin
                r_q <= {r_q[fls_pkg::RATIO_W-2:0], w_ge};
                r_rem <= w_ge ? fls_pkg::FIB_W'(w_rem2 - {1'b0, r_den})
                              : fls_pkg::FIB_W'(w_rem2);
            end
        end
    end

    assign o_ratio = r_q;
    assign o_done  = r_done;

endmodule

[sv/fls_mul.sv]
module fls_mul (
    input  logic           i_clk,
    input  fls_pkg::t_mul  i_op_a,
    input  fls_pkg::t_mul  i_op_b,
    output fls_pkg::t_prod o_prod
);

    fls_pkg::t_prod r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= i_op_a * i_op_b;
    end

    assign o_prod = r_prod;

endmodule

[sv/fibonacci_line_search.sv]
// Channel  | Direction | Handshake          | Payload
// input    | in        | i_valid / o_stall  | interval start, interval end, tolerance
// result   | out       | o_valid / i_stall  | midpoint, length, iteration count, saturated
//
// One item first searches for the iteration count n (up to 47), then takes the
// two ratios one after the other on the bit-serial divider, and then evaluates
// each point on the shared multiplier (four products each).
// Reset is synchronous and active low; it clears the sequencer and output valid.
// The input is stalled from acceptance until the result is loaded into the
// output register; a stalled result holds there while the next item runs.
module fibonacci_line_search (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic signed [31:0] i_interval_start,
    input  logic signed [31:0] i_interval_end,
    input  logic [30:0]        i_tolerance,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_final_midpoint,
    output logic signed [31:0] o_final_length,
    output logic [5:0]         o_iteration_count,
    output logic               o_saturated
);

    fls_pkg::t_state r_state;
    fls_pkg::t_state n_state;

    logic signed [31:0]            r_a;
    logic signed [31:0]            r_b;
    logic signed [31:0]            r_c;
    logic signed [31:0]            r_d;
    logic signed [31:0]            r_fc;
    logic signed [31:0]            r_fd;
    logic signed [31:0]            r_x;
    logic signed [31:0]            r_x2;
    logic [32:0]                   r_t;
    logic [fls_pkg::RATIO_W-1:0]   r_r1;
    logic [fls_pkg::RATIO_W-1:0]   r_r2;
    logic [fls_pkg::FIB_W-1:0]     r_f0;
    logic [fls_pkg::FIB_W-1:0]     r_f1;
    logic [fls_pkg::FIB_W-1:0]     r_f2;
    logic [fls_pkg::P_W-1:0]       r_pp;
    logic [fls_pkg::P_W-1:0]       r_p;
    logic [fls_pkg::IDX_W-1:0]     r_i;
    logic [fls_pkg::IDX_W-1:0]     r_left;
    logic                          r_side;
    logic                          r_first;
    logic                          r_flag;
    logic                          r_out_valid;
    logic signed [31:0]            r_out_mid;
    logic signed [31:0]            r_out_len;
    logic [5:0]                    r_out_cnt;
    logic                          r_out_sat;

    logic                          w_in_xfer;
    logic                          w_out_free;
    logic signed [32:0]            w_diff;
    logic signed [fls_pkg::P_W:0]  w_pcmp;
    logic signed [fls_pkg::P_W:0]  w_dcmp;
    logic                          w_cnt_hit;
    logic                          w_cnt_end;
    fls_pkg::t_div_req             w_div_req;
    logic [fls_pkg::RATIO_W-1:0]   w_ratio;
    logic                          w_div_done;
    fls_pkg::t_mul                 w_op_a;
    fls_pkg::t_mul                 w_op_b;
    fls_pkg::t_prod                w_prod;
    fls_pkg::t_sat                 w_probe;
    fls_pkg::t_sat                 w_sq;
    fls_pkg::t_sat                 w_cu;
    fls_pkg::t_sat                 w_fval;
    fls_pkg::t_sat                 w_len;
    fls_pkg::t_wide                w_cu_t;
    fls_pkg::t_wide                w_mid;

    assign w_in_xfer  = i_valid && !o_stall;
    assign w_out_free = !r_out_valid || !i_stall;

    assign w_diff    = {r_b[31], r_b} - {r_a[31], r_a};
    assign w_pcmp    = {1'b0, r_p};
    assign w_dcmp    = {{(fls_pkg::P_W - 32){w_diff[32]}}, w_diff};
    assign w_cnt_hit = (w_pcmp > w_dcmp);
    assign w_cnt_end = w_cnt_hit || (r_i == fls_pkg::IDX_W'(fls_pkg::MAX_FIB_INDEX));

    fls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div_req),
        .o_ratio (w_ratio),
        .o_done  (w_div_done)
    );

    fls_mul u_mul (
        .i_clk  (i_clk),
        .i_op_a (w_op_a),
        .i_op_b (w_op_b),
        .o_prod (w_prod)
    );

    // Post-processing of the registered product, one use per state.
    assign w_probe = fls_pkg::sat32(fls_pkg::t_wide'(r_a)
        + fls_pkg::t_wide'((w_prod + fls_pkg::ROUND_R) >>> fls_pkg::RATIO_BITS));
    assign w_sq = fls_pkg::sat32(
        fls_pkg::t_wide'((w_prod + fls_pkg::ROUND_F) >>> fls_pkg::FRAC_BITS));
    assign w_cu = w_sq;
    assign w_cu_t = fls_pkg::t_wide'(w_cu.val) + fls_pkg::t_wide'(1)
        + fls_pkg::t_wide'(fls_pkg::THIRD_OFS);
    assign w_fval = fls_pkg::sat32(
        fls_pkg::t_wide'(w_prod >>> fls_pkg::RECIP_SHIFT)
        - fls_pkg::t_wide'(fls_pkg::THIRD_K)
        - ((fls_pkg::t_wide'(r_x2) + fls_pkg::t_wide'(1)) >>> 1)
        - fls_pkg::t_wide'(r_x)
        - fls_pkg::ONE_FX);
    assign w_len = fls_pkg::sat32(fls_pkg::t_wide'(r_b) - fls_pkg::t_wide'(r_a));
    assign w_mid = (fls_pkg::t_wide'(r_a) + fls_pkg::t_wide'(r_b)) >>> 1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            fls_pkg::S_IDLE:  if (w_in_xfer) n_state = fls_pkg::S_COUNT;
            fls_pkg::S_COUNT: if (w_cnt_end) n_state = fls_pkg::S_DIV1;
            fls_pkg::S_DIV1:  n_state = fls_pkg::S_WAIT1;
            fls_pkg::S_WAIT1: if (w_div_done) n_state = fls_pkg::S_DIV2;
            fls_pkg::S_DIV2:  n_state = fls_pkg::S_WAIT2;
            fls_pkg::S_WAIT2: if (w_div_done) n_state = fls_pkg::S_PMUL;
            fls_pkg::S_PMUL:  n_state = fls_pkg::S_PROBE;
            fls_pkg::S_PROBE: n_state = fls_pkg::S_SQMUL;
            fls_pkg::S_SQMUL: n_state = fls_pkg::S_SQ;
            fls_pkg::S_SQ:    n_state = fls_pkg::S_CUMUL;
            fls_pkg::S_CUMUL: n_state = fls_pkg::S_CU;
            fls_pkg::S_CU:    n_state = fls_pkg::S_THMUL;
            fls_pkg::S_THMUL: n_state = fls_pkg::S_FVAL;
            fls_pkg::S_FVAL:  n_state = r_first ? fls_pkg::S_PMUL : fls_pkg::S_STEP;
            fls_pkg::S_STEP:  n_state = (r_left == '0) ? fls_pkg::S_DONE : fls_pkg::S_PMUL;
            fls_pkg::S_DONE:  if (w_out_free) n_state = fls_pkg::S_IDLE;
            default:          n_state = fls_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        o_stall       = (r_state != fls_pkg::S_IDLE);
        w_div_req     = '0;
        w_div_req.den = r_f2;
        w_div_req.num = r_f0;
        w_op_a        = '0;
        w_op_b        = '0;
        unique case (r_state)
            fls_pkg::S_DIV1: begin
                w_div_req.start = 1'b1;
            end
            fls_pkg::S_DIV2: begin
                w_div_req.start = 1'b1;
                w_div_req.num   = r_f1;
            end
            fls_pkg::S_PMUL: begin
                w_op_a = fls_pkg::t_mul'({1'b0, r_side ? r_r2 : r_r1});
                w_op_b = fls_pkg::t_mul'(w_diff);
            end
            fls_pkg::S_SQMUL: begin
                w_op_a = fls_pkg::t_mul'(r_x);
                w_op_b = fls_pkg::t_mul'(r_x);
            end
            fls_pkg::S_CUMUL: begin
                w_op_a = fls_pkg::t_mul'(r_x2);
                w_op_b = fls_pkg::t_mul'(r_x);
            end
            fls_pkg::S_THMUL: begin
                w_op_a = fls_pkg::t_mul'({1'b0, r_t});
                w_op_b = fls_pkg::t_mul'(fls_pkg::RECIP3);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fls_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == fls_pkg::S_DONE && w_out_free) begin
            r_out_valid <= 1'b1;
        end else if (r_out_valid && !i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            fls_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    r_a    <= i_interval_start;
                    r_b    <= i_interval_end;
                    r_f0   <= fls_pkg::FIB_W'(1);
                    r_f1   <= fls_pkg::FIB_W'(1);
                    r_f2   <= fls_pkg::FIB_W'(2);
                    r_pp   <= fls_pkg::P_W'(i_tolerance);
                    r_p    <= fls_pkg::P_W'({i_tolerance, 1'b0});
                    r_i    <= fls_pkg::IDX_W'(2);
                    r_flag <= 1'b0;
                end
            end
            fls_pkg::S_COUNT: begin
                if (w_cnt_end) begin
                    r_left <= r_i - 1'b1;
                    if (!w_cnt_hit) begin
                        r_flag <= 1'b1;
                    end
                end else begin
                    // Step the sequence and its multiples of the tolerance together.
                    r_f0 <= r_f1;
                    r_f1 <= r_f2;
                    r_f2 <= r_f1 + r_f2;
                    r_pp <= r_p;
                    r_p  <= r_p + r_pp;
                    r_i  <= r_i + 1'b1;
                end
            end
            fls_pkg::S_WAIT1: begin
                if (w_div_done) begin
                    r_r1 <= w_ratio;
                end
            end
            fls_pkg::S_WAIT2: begin
                if (w_div_done) begin
                    r_r2    <= w_ratio;
                    r_side  <= 1'b0;
                    r_first <= 1'b1;
                end
            end
            fls_pkg::S_PROBE: begin
                r_x    <= w_probe.val;
                r_flag <= r_flag | w_probe.ovf;
            end
            fls_pkg::S_SQ: begin
                r_x2   <= w_sq.val;
                r_flag <= r_flag | w_sq.ovf;
            end
            fls_pkg::S_CU: begin
                r_t    <= w_cu_t[32:0];
                r_flag <= r_flag | w_cu.ovf;
            end
            fls_pkg::S_FVAL: begin
                r_flag <= r_flag | w_fval.ovf;
                if (r_side) begin
                    r_d  <= r_x;
                    r_fd <= w_fval.val;
                end else begin
                    r_c  <= r_x;
                    r_fc <= w_fval.val;
                end
                if (r_first) begin
                    r_first <= 1'b0;
                    r_side  <= 1'b1;
                end
            end
            fls_pkg::S_STEP: begin
                if (r_left != '0) begin
                    r_left <= r_left - 1'b1;
                    // On a tie the left end moves.
                    if (r_fc < r_fd) begin
                        r_b    <= r_d;
                        r_d    <= r_c;
                        r_fd   <= r_fc;
                        r_side <= 1'b0;
                    end else begin
                        r_a    <= r_c;
                        r_c    <= r_d;
                        r_fc   <= r_fd;
                        r_side <= 1'b1;
                    end
                end
            end
            fls_pkg::S_DONE: begin
                if (w_out_free) begin
                    r_out_mid <= w_mid[31:0];
                    r_out_len <= w_len.val;
                    r_out_cnt <= 6'(r_i);
                    r_out_sat <= r_flag | w_len.ovf;
                end
            end
            default: begin
            end
        endcase
    end

    assign o_valid           = r_out_valid;
    assign o_final_midpoint  = r_out_mid;
    assign o_final_length    = r_out_len;
    assign o_iteration_count = r_out_cnt;
    assign o_saturated       = r_out_sat;

endmodule

[sv/fls_checker.sv]
module fls_props (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_valid,
    input logic               o_stall,
    input logic signed [31:0] i_interval_start,
    input logic signed [31:0] i_interval_end,
    input logic [30:0]        i_tolerance,
    input logic               o_valid,
    input logic               i_stall,
    input logic signed [31:0] o_final_midpoint,
    input logic signed [31:0] o_final_length,
    input logic [5:0]         o_iteration_count,
    input logic               o_saturated
);

    // After reset nothing is pending on either side.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("block not idle after reset");

    // A transfer on the input starts a search; the input stays stalled after it.
    a_busy_after_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall ##1 o_stall)
        else $error("input not stalled after a transfer");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_iteration_count >= 6'd2
            && o_iteration_count <= 6'(fls_pkg::MAX_FIB_INDEX))
        else $error("iteration count out of range");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_final_midpoint)
            && $stable(o_final_length) && $stable(o_iteration_count)
            && $stable(o_saturated))
        else $error("stalled result changed");

endmodule

bind fibonacci_line_search fls_props u_fls_props (.*);
